// ===== hdl/gbs_pkg.sv =====
// shared types and constants of the greedy box suppression block
package gbs_pkg;

   localparam int COORD_W     = 12;
   localparam int SIZE_W      = 11;
   localparam int SCORE_W     = 16;
   localparam int THR_W       = 16;
   localparam int KEPT_W      = 6;
   localparam int MAX_RESULTS = 64;
   localparam int RES_CNT_W   = 7;
   localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

   typedef struct packed {
      logic signed [COORD_W-1:0] box_center_x;
      logic signed [COORD_W-1:0] box_center_y;
      logic        [SIZE_W-1:0]  box_width;
      logic        [SIZE_W-1:0]  box_height;
      logic        [SCORE_W-1:0] score;
      logic                      last_box;
   } req_type;

   typedef struct packed {
      logic [KEPT_W-1:0] kept_index;
      logic              last_kept;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] box_center_x;
      logic signed [COORD_W-1:0] box_center_y;
      logic        [SIZE_W-1:0]  box_width;
      logic        [SIZE_W-1:0]  box_height;
   } box_type;

   typedef struct packed {
      box_type                box;
      logic [SCORE_W-1:0]     score;
   } entry_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RK_HEAD,
      ST_RK_CAP,
      ST_RK_SCAN,
      ST_RK_WR,
      ST_NM_HEAD,
      ST_NM_CHK,
      ST_NM_KEEP,
      ST_NM_PUSH,
      ST_NM_RD_J,
      ST_NM_RD_B,
      ST_NM_IOU,
      ST_NM_WAIT,
      ST_NM_FIN
   } state_type;

endpackage

// ===== hdl/greedy_box_suppression.sv =====
// greedy box suppression top level: box loading, score ranking and suppression walk
//
//  channel | ports                          | beat
//  req     | req_valid req_ready req_data   | one box, last_box ends the frame
//  rsp     | rsp_valid rsp_ready rsp_data   | one kept index, last_kept on the final one
//  csr     | csr_valid csr_ready csr_wdata  | iou threshold write, always ready
//
// loading takes one cycle per box; req_ready drops from the last box until the frame is done
// ranking counts higher scores over the entry memory for each box in turn
// suppression takes one pair at a time through the rank memory, entry memory and iou unit
// reset is synchronous; no clearing pass, marks are cleared as the rank pass writes each slot
// a stalled rsp holds the walk when a second kept index is ready to go out, and holds the final beat
module greedy_box_suppression #(
   parameter int MAX_BOXES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  gbs_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output gbs_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [gbs_pkg::THR_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int KW    = gbs_pkg::KEPT_W;
   localparam int RCW   = gbs_pkg::RES_CNT_W;

   gbs_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, jd_ff, jd_in;
   logic             q_vld_ff, q_vld_in;
   logic [gbs_pkg::SCORE_W-1:0] si_ff, si_in;
   logic [IDX_W-1:0] rank_cnt_ff, rank_cnt_in;
   logic [IDX_W-1:0] a_ff, a_in, b_ff, b_in, pend_ff, pend_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [RCW-1:0]   kept_cnt_ff, kept_cnt_in;
   gbs_pkg::box_type abox_ff, abox_in;
   logic [gbs_pkg::THR_W-1:0] thr_ff;
   logic             rsp_valid_ff;
   gbs_pkg::rsp_type rsp_data_ff;

   // entry memory: box geometry and score
   gbs_pkg::entry_type entry_mem [MAX_BOXES];
   gbs_pkg::entry_type en_q_ff;
   gbs_pkg::entry_type en_wdata;
   logic               en_we;
   logic [IDX_W-1:0]   en_raddr;

   // rank memory: suppressed mark and load index, by rank position
   logic [IDX_W:0]     rank_mem [MAX_BOXES];
   logic [IDX_W:0]     rk_q_ff;
   logic [IDX_W:0]     rk_wdata;
   logic               rk_we;
   logic [IDX_W-1:0]   rk_waddr, rk_raddr;

   logic             iou_start, iou_done, iou_supp;
   logic             push, slot_free;
   gbs_pkg::rsp_type push_data;
   logic             req_acc;

   assign req_acc   = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   gbs_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .start     (iou_start),
      .box_a     (abox_ff),
      .box_b     (en_q_ff.box),
      .threshold (thr_ff),
      .done      (iou_done),
      .suppress  (iou_supp)
   );

   always_ff @(posedge clock) begin
      if (en_we) begin
         entry_mem[cnt_ff[IDX_W-1:0]] <= en_wdata;
      end
      en_q_ff <= entry_mem[en_raddr];
      if (rk_we) begin
         rank_mem[rk_waddr] <= rk_wdata;
      end
      rk_q_ff <= rank_mem[rk_raddr];
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      jd_in       = jd_ff;
      q_vld_in    = 1'b0;
      si_in       = si_ff;
      rank_cnt_in = rank_cnt_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      kept_cnt_in = kept_cnt_ff;
      abox_in     = abox_ff;
      req_ready   = 1'b0;
      en_we       = 1'b0;
      en_wdata    = '{box: '{box_center_x: req_data.box_center_x,
                             box_center_y: req_data.box_center_y,
                             box_width:    req_data.box_width,
                             box_height:   req_data.box_height},
                      score: req_data.score};
      en_raddr    = '0;
      rk_we       = 1'b0;
      rk_waddr    = rank_cnt_ff;
      rk_wdata    = {1'b0, i_ff[IDX_W-1:0]};
      rk_raddr    = '0;
      iou_start   = 1'b0;
      push        = 1'b0;
      push_data   = '{kept_index: KW'(pend_ff), last_kept: 1'b0};
      case (state_ff)
         gbs_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_acc) begin
               // boxes past capacity are dropped but still end the frame
               if (cnt_ff < CNT_W'(MAX_BOXES)) begin
                  en_we  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_data.last_box) begin
                  i_in     = '0;
                  state_in = gbs_pkg::ST_RK_HEAD;
               end
            end
         end
         gbs_pkg::ST_RK_HEAD: begin
            en_raddr = i_ff[IDX_W-1:0];
            if (i_ff == cnt_ff) begin
               i_in        = '0;
               pend_vld_in = 1'b0;
               kept_cnt_in = '0;
               state_in    = gbs_pkg::ST_NM_HEAD;
            end else begin
               state_in = gbs_pkg::ST_RK_CAP;
            end
         end
         gbs_pkg::ST_RK_CAP: begin
            si_in       = en_q_ff.score;
            j_in        = '0;
            rank_cnt_in = '0;
            state_in    = gbs_pkg::ST_RK_SCAN;
         end
         gbs_pkg::ST_RK_SCAN: begin
            // higher score, or equal score at a lower load index, ranks ahead
            if (q_vld_ff && ((en_q_ff.score > si_ff) ||
                             ((en_q_ff.score == si_ff) && (jd_ff < i_ff)))) begin
               rank_cnt_in = rank_cnt_ff + 1'b1;
            end
            if (j_ff < cnt_ff) begin
               en_raddr = j_ff[IDX_W-1:0];
               jd_in    = j_ff;
               q_vld_in = 1'b1;
               j_in     = j_ff + 1'b1;
            end else if (!q_vld_ff) begin
               state_in = gbs_pkg::ST_RK_WR;
            end
         end
         gbs_pkg::ST_RK_WR: begin
            rk_we    = 1'b1;
            i_in     = i_ff + 1'b1;
            state_in = gbs_pkg::ST_RK_HEAD;
         end
         gbs_pkg::ST_NM_HEAD: begin
            rk_raddr = i_ff[IDX_W-1:0];
            state_in = (i_ff == cnt_ff) ? gbs_pkg::ST_NM_FIN : gbs_pkg::ST_NM_CHK;
         end
         gbs_pkg::ST_NM_CHK: begin
            if (rk_q_ff[IDX_W]) begin
               i_in     = i_ff + 1'b1;
               state_in = gbs_pkg::ST_NM_HEAD;
            end else begin
               a_in     = rk_q_ff[IDX_W-1:0];
               en_raddr = rk_q_ff[IDX_W-1:0];
               state_in = gbs_pkg::ST_NM_KEEP;
            end
         end
         gbs_pkg::ST_NM_KEEP: begin
            abox_in  = en_q_ff.box;
            state_in = gbs_pkg::ST_NM_PUSH;
         end
         gbs_pkg::ST_NM_PUSH: begin
            // the previous kept index goes out once a newer one is known
            if (kept_cnt_ff < RCW'(gbs_pkg::MAX_RESULTS)) begin
               if (!pend_vld_ff || slot_free) begin
                  push        = pend_vld_ff;
                  pend_in     = a_ff;
                  pend_vld_in = 1'b1;
                  kept_cnt_in = kept_cnt_ff + 1'b1;
                  j_in        = i_ff + 1'b1;
                  state_in    = gbs_pkg::ST_NM_RD_J;
               end
            end else begin
               j_in     = i_ff + 1'b1;
               state_in = gbs_pkg::ST_NM_RD_J;
            end
         end
         gbs_pkg::ST_NM_RD_J: begin
            rk_raddr = j_ff[IDX_W-1:0];
            if (j_ff == cnt_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = gbs_pkg::ST_NM_HEAD;
            end else begin
               state_in = gbs_pkg::ST_NM_RD_B;
            end
         end
         gbs_pkg::ST_NM_RD_B: begin
            if (rk_q_ff[IDX_W]) begin
               j_in     = j_ff + 1'b1;
               state_in = gbs_pkg::ST_NM_RD_J;
            end else begin
               b_in     = rk_q_ff[IDX_W-1:0];
               en_raddr = rk_q_ff[IDX_W-1:0];
               state_in = gbs_pkg::ST_NM_IOU;
            end
         end
         gbs_pkg::ST_NM_IOU: begin
            iou_start = 1'b1;
            state_in  = gbs_pkg::ST_NM_WAIT;
         end
         gbs_pkg::ST_NM_WAIT: begin
            if (iou_done) begin
               rk_we    = iou_supp;
               rk_waddr = j_ff[IDX_W-1:0];
               rk_wdata = {1'b1, b_ff};
               j_in     = j_ff + 1'b1;
               state_in = gbs_pkg::ST_NM_RD_J;
            end
         end
         gbs_pkg::ST_NM_FIN: begin
            if (slot_free) begin
               push      = 1'b1;
               push_data = '{kept_index: KW'(pend_ff), last_kept: 1'b1};
               cnt_in    = '0;
               state_in  = gbs_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = gbs_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbs_pkg::ST_LOAD;
         cnt_ff       <= '0;
         q_vld_ff     <= 1'b0;
         pend_vld_ff  <= 1'b0;
         kept_cnt_ff  <= '0;
         thr_ff       <= gbs_pkg::THR_RESET;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         q_vld_ff    <= q_vld_in;
         pend_vld_ff <= pend_vld_in;
         kept_cnt_ff <= kept_cnt_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         if (csr_valid) begin
            thr_ff <= csr_wdata;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      jd_ff       <= jd_in;
      si_ff       <= si_in;
      rank_cnt_ff <= rank_cnt_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      pend_ff     <= pend_in;
      abox_ff     <= abox_in;
      if (push) begin
         rsp_data_ff <= push_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      iou_done |-> (state_ff == gbs_pkg::ST_NM_WAIT))
      else $error("overlap result arrived outside the wait state");

   a_frame_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbs_pkg::ST_NM_HEAD) |-> (cnt_ff != '0))
      else $error("suppression walk started on an empty frame");

   a_later_rank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbs_pkg::ST_NM_RD_B) |-> (j_ff > i_ff) && (j_ff < cnt_ff))
      else $error("inner walk index not after the kept box");

   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_cnt_ff <= RCW'(gbs_pkg::MAX_RESULTS))
      else $error("kept count beyond result limit");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> slot_free)
      else $error("result pushed into a full output register");

endmodule

// ===== hdl/gbs_iou.sv =====
// four-stage pairwise overlap test: intersection against threshold times union
module gbs_iou (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  gbs_pkg::box_type            box_a,
   input  gbs_pkg::box_type            box_b,
   input  logic [gbs_pkg::THR_W-1:0]   threshold,
   output logic                        done,
   output logic                        suppress
);

   localparam int XW = gbs_pkg::COORD_W + 1;
   localparam int DW = gbs_pkg::COORD_W + 2;
   localparam int SW = gbs_pkg::SIZE_W;
   localparam int AW = 2 * gbs_pkg::SIZE_W;
   localparam int UW = AW + 1;
   localparam int LW = AW + 16;
   localparam int RW = UW + gbs_pkg::THR_W;

   logic [3:0] vld_ff;

   logic signed [XW-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
   logic signed [XW-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [DW-1:0] dx, dy;
   logic [SW-1:0] iw_in, ih_in, aw_in, ah_in, bw_in, bh_in;

   logic [SW-1:0] iw_ff, ih_ff, aw_ff, ah_ff, bw_ff, bh_ff;
   logic [AW-1:0] inter_ff, area_a_ff, area_b_ff;
   logic [AW-1:0] inter2_ff;
   logic [UW-1:0] uni_ff;
   logic          supp_ff;
   logic [LW-1:0] lhs;
   logic [RW-1:0] rhs;

   always_comb begin
      ax0 = XW'(box_a.box_center_x) - XW'($signed({1'b0, box_a.box_width[SW-1:1]}));
      ax1 = XW'(box_a.box_center_x) + XW'($signed({1'b0, box_a.box_width[SW-1:1]}));
      ay0 = XW'(box_a.box_center_y) - XW'($signed({1'b0, box_a.box_height[SW-1:1]}));
      ay1 = XW'(box_a.box_center_y) + XW'($signed({1'b0, box_a.box_height[SW-1:1]}));
      bx0 = XW'(box_b.box_center_x) - XW'($signed({1'b0, box_b.box_width[SW-1:1]}));
      bx1 = XW'(box_b.box_center_x) + XW'($signed({1'b0, box_b.box_width[SW-1:1]}));
      by0 = XW'(box_b.box_center_y) - XW'($signed({1'b0, box_b.box_height[SW-1:1]}));
      by1 = XW'(box_b.box_center_y) + XW'($signed({1'b0, box_b.box_height[SW-1:1]}));
      lo_x = (ax0 > bx0) ? ax0 : bx0;
      hi_x = (ax1 < bx1) ? ax1 : bx1;
      lo_y = (ay0 > by0) ? ay0 : by0;
      hi_y = (ay1 < by1) ? ay1 : by1;
      dx = DW'(hi_x) - DW'(lo_x);
      dy = DW'(hi_y) - DW'(lo_y);
      iw_in = (dx > 0) ? SW'(dx) : '0;
      ih_in = (dy > 0) ? SW'(dy) : '0;
      // spans are twice the truncated half sizes
      aw_in = {box_a.box_width[SW-1:1], 1'b0};
      ah_in = {box_a.box_height[SW-1:1], 1'b0};
      bw_in = {box_b.box_width[SW-1:1], 1'b0};
      bh_in = {box_b.box_height[SW-1:1], 1'b0};
      lhs = {inter2_ff, 16'b0};
      rhs = RW'(threshold) * RW'(uni_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      aw_ff     <= aw_in;
      ah_ff     <= ah_in;
      bw_ff     <= bw_in;
      bh_ff     <= bh_in;
      inter_ff  <= AW'(iw_ff) * AW'(ih_ff);
      area_a_ff <= AW'(aw_ff) * AW'(ah_ff);
      area_b_ff <= AW'(bw_ff) * AW'(bh_ff);
      inter2_ff <= inter_ff;
      uni_ff    <= UW'(area_a_ff) + UW'(area_b_ff) - UW'(inter_ff);
      // zero union never suppresses
      supp_ff   <= (uni_ff != '0) && (RW'(lhs) > rhs);
   end

   assign done     = vld_ff[3];
   assign suppress = supp_ff;

endmodule

// ===== tb/gbs_kept_checker.sv =====
// checker for greedy box suppression: predicts kept indices per frame and compares rsp beats
`timescale 1ns / 100ps

module gbs_kept_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  gbs_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  gbs_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [gbs_pkg::THR_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending,
   output int                        kept_seen
);

   localparam int BOX_CAP = 64;

   gbs_pkg::box_type            frame_boxes [BOX_CAP];
   logic [gbs_pkg::SCORE_W-1:0] frame_scores[BOX_CAP];
   int                          frame_fill;
   logic [gbs_pkg::THR_W-1:0]   threshold;
   gbs_pkg::rsp_type            kept_queue[$];

   assign pending = kept_queue.size();

   function automatic bit overlaps_too_much(gbs_pkg::box_type a, gbs_pkg::box_type b,
                                            logic [gbs_pkg::THR_W-1:0] thr);
      longint ahw, ahh, bhw, bhh, ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
      longint iw, ih, inter, uni;
      ahw = longint'(a.box_width) / 2;
      ahh = longint'(a.box_height) / 2;
      bhw = longint'(b.box_width) / 2;
      bhh = longint'(b.box_height) / 2;
      ax0 = longint'(a.box_center_x) - ahw;
      ax1 = longint'(a.box_center_x) + ahw;
      ay0 = longint'(a.box_center_y) - ahh;
      ay1 = longint'(a.box_center_y) + ahh;
      bx0 = longint'(b.box_center_x) - bhw;
      bx1 = longint'(b.box_center_x) + bhw;
      by0 = longint'(b.box_center_y) - bhh;
      by1 = longint'(b.box_center_y) + bhh;
      iw = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
      ih = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      inter = iw * ih;
      uni = (ax1 - ax0) * (ay1 - ay0) + (bx1 - bx0) * (by1 - by0) - inter;
      if (uni <= 0) return 0;
      return inter * 65536 > longint'(thr) * uni;
   endfunction

   // stable descending sort, then greedy walk in rank order
   task automatic predict_survivors();
      int order[BOX_CAP];
      bit gone[BOX_CAP];
      int i, j, a, cnt;
      gbs_pkg::rsp_type r;
      cnt = 0;
      for (i = 0; i < frame_fill; i++) begin
         j = i;
         while (j > 0 && frame_scores[order[j-1]] < frame_scores[i]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
         gone[i] = 0;
      end
      for (i = 0; i < frame_fill; i++) begin
         a = order[i];
         if (!gone[a]) begin
            r.kept_index = a[gbs_pkg::KEPT_W-1:0];
            r.last_kept  = 1'b0;
            kept_queue = {kept_queue, r};
            cnt++;
            for (j = i + 1; j < frame_fill; j++)
               if (!gone[order[j]] &&
                   overlaps_too_much(frame_boxes[a], frame_boxes[order[j]], threshold))
                  gone[order[j]] = 1;
         end
      end
      if (cnt > 0) kept_queue[kept_queue.size()-1].last_kept = 1'b1;
      frame_fill = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_fill = 0;
         threshold  = gbs_pkg::THR_RESET;
         kept_queue.delete();
         fail_count <= 0;
         kept_seen  <= 0;
      end else begin
         if (csr_valid && csr_ready) threshold = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            kept_seen <= kept_seen + 1;
            if (kept_queue.size() == 0) begin
               $error("unexpected rsp beat: kept_index %0d last_kept %0d",
                      rsp_data.kept_index, rsp_data.last_kept);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_data.kept_index !== kept_queue[0].kept_index) begin
                  $error("kept_index expected %0d actual %0d",
                         kept_queue[0].kept_index, rsp_data.kept_index);
                  fail_count <= fail_count + 1;
               end else if (rsp_data.last_kept !== kept_queue[0].last_kept) begin
                  $error("last_kept expected %0d actual %0d",
                         kept_queue[0].last_kept, rsp_data.last_kept);
                  fail_count <= fail_count + 1;
               end
               void'(kept_queue.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            // boxes past capacity are dropped but last_box still ends the frame
            if (frame_fill < BOX_CAP) begin
               frame_boxes[frame_fill] = '{req_data.box_center_x, req_data.box_center_y,
                                           req_data.box_width, req_data.box_height};
               frame_scores[frame_fill] = req_data.score;
               frame_fill++;
            end
            if (req_data.last_box) predict_survivors();
         end
      end
   end

endmodule

// ===== tb/greedy_box_suppression_tb.sv =====
// testbench top for greedy box suppression: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module greedy_box_suppression_tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_TARGET = 470;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_valid = 0;
   logic                      req_ready;
   gbs_pkg::req_type          req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 0;
   gbs_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 0;
   logic                      csr_ready;
   logic [gbs_pkg::THR_W-1:0] csr_wdata = '0;

   int fail_count, pending, kept_seen;
   int cycles = 0;
   int items_sent = 0;
   int frames_sent = 0;
   int idle_pct = 73;
   bit sender_idles = 0;
   bit receiver_stalls = 0;

   greedy_box_suppression dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   gbs_kept_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .kept_seen(kept_seen)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= receiver_stalls ? ($urandom_range(99) >= idle_pct) : 1'b1;
   end

   task automatic send_box(gbs_pkg::req_type beat);
      int gap;
      gap = 0;
      if (sender_idles)
         while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (beat.last_box) frames_sent++;
   endtask

   task automatic send_raw(int cx, int cy, int w, int h, int sc, bit last);
      gbs_pkg::req_type beat;
      beat.box_center_x = cx[gbs_pkg::COORD_W-1:0];
      beat.box_center_y = cy[gbs_pkg::COORD_W-1:0];
      beat.box_width    = w[gbs_pkg::SIZE_W-1:0];
      beat.box_height   = h[gbs_pkg::SIZE_W-1:0];
      beat.score        = sc[gbs_pkg::SCORE_W-1:0];
      beat.last_box     = last;
      send_box(beat);
   endtask

   // hold off until every kept index is out, then let the walk finish
   task automatic wait_drained();
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_threshold(logic [gbs_pkg::THR_W-1:0] thr);
      csr_valid <= 1'b1;
      csr_wdata <= thr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly clustered boxes so suppression actually fires; some full-range noise
   task automatic random_frame(int n);
      int bx, by, i, cx, cy, w, h, sc;
      bit noise, ties;
      noise = ($urandom_range(99) < 20);
      ties  = ($urandom_range(99) < 25);
      bx = $urandom_range(3000) - 1500;
      by = $urandom_range(3000) - 1500;
      for (i = 0; i < n; i++) begin
         if (noise) begin
            cx = $urandom_range(4095);
            cy = $urandom_range(4095);
            w  = $urandom_range(2047);
            h  = $urandom_range(2047);
         end else begin
            cx = bx + $urandom_range(60) - 30;
            cy = by + $urandom_range(60) - 30;
            w  = $urandom_range(200, 10);
            h  = $urandom_range(200, 10);
         end
         sc = ties ? $urandom_range(3) : $urandom_range(65535);
         send_raw(cx, cy, w, h, sc, i == n - 1);
      end
   endtask

   initial begin
      logic [gbs_pkg::THR_W-1:0] phase_thr[6];
      int phase, n;
      phase_thr = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd16384, 16'd0};
      phase_thr[5] = $urandom_range(65535);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames, first at the reset threshold, then at thresholds 0 and 65535
      send_raw(-2048, 2047, 2047, 2047, 65535, 1);
      send_raw(0, 0, 0, 0, 0, 0);            // zero union pair, tied scores
      send_raw(0, 0, 0, 0, 0, 1);
      send_raw(0, 0, 100, 100, 500, 0);      // identical boxes, best one wins
      send_raw(0, 0, 100, 100, 500, 0);
      send_raw(0, 0, 100, 100, 900, 1);
      send_raw(2047, -2048, 2047, 1, 65535, 0);
      send_raw(-2048, 2047, 1, 2047, 65535, 0);
      send_raw(5, 5, 3, 3, 0, 1);
      wait_drained();
      write_threshold(16'd0);
      send_raw(0, 0, 10, 10, 7, 0);          // touching edges, no overlap
      send_raw(10, 0, 10, 10, 9, 0);
      send_raw(3, 0, 10, 10, 8, 1);
      wait_drained();
      write_threshold(16'd65535);
      send_raw(100, 100, 50, 50, 1, 0);
      send_raw(100, 100, 50, 50, 2, 0);
      send_raw(101, 100, 50, 50, 3, 1);

      for (phase = 0; phase < 6; phase++) begin
         wait_drained();
         write_threshold(phase_thr[phase]);
         sender_idles    = (phase % 4 == 1) || (phase % 4 == 3);
         receiver_stalls = (phase % 4 == 2) || (phase % 4 == 3);
         idle_pct        = (phase % 4 == 3) ? 25 : 73;
         if (phase == 2) random_frame(67);   // past capacity
         if (phase == 5) random_frame(64);
         while (items_sent < ITEM_TARGET * (phase + 1) / 6) begin
            n = ($urandom_range(99) < 10) ? $urandom_range(24, 12) : $urandom_range(10, 1);
            random_frame(n);
            if ($urandom_range(99) < 10) wait_drained();
         end
      end

      @(posedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d boxes in %0d frames, %0d kept indices, six thresholds",
               items_sent, frames_sent, kept_seen);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
